>>> design/jhp_pkg.sv
// Package for the JPEG header marker parser: parse phases, record kinds,
// the record word type passed between front and back, and the zigzag table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jhp_pkg;

    // Number of entries in one quantization table.
    localparam int QUANT_ENTRIES = 64;
    localparam int QPOS_W        = $clog2(QUANT_ENTRIES);

    // Depth of the record queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Marker bytes.
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_DQT    = 8'hDB;
    localparam logic [7:0] MARK_COM    = 8'hFE;

    typedef enum logic [3:0] {
        PH_SOI0      = 4'd0,
        PH_SOI1      = 4'd1,
        PH_SCAN      = 4'd2,
        PH_DEAD      = 4'd3,
        PH_SOF_LEN   = 4'd4,
        PH_SOF_PREC  = 4'd5,
        PH_SOF_H     = 4'd6,
        PH_SOF_W     = 4'd7,
        PH_SOF_N     = 4'd8,
        PH_SOF_COMP  = 4'd9,
        PH_DQT_LEN   = 4'd10,
        PH_DQT_HDR   = 4'd11,
        PH_DQT_ENT   = 4'd12,
        PH_COM_LEN   = 4'd13,
        PH_COM_BYTES = 4'd14
    } phase_t;

    typedef enum logic [3:0] {
        KIND_NOT_JPEG  = 4'd0,
        KIND_PRECISION = 4'd1,
        KIND_HEIGHT    = 4'd2,
        KIND_WIDTH     = 4'd3,
        KIND_NCOMP     = 4'd4,
        KIND_COMPONENT = 4'd5,
        KIND_QHEADER   = 4'd6,
        KIND_QENTRY    = 4'd7,
        KIND_COMMENT   = 4'd8
    } kind_t;

    // One result word. For quant entries the front puts the zigzag
    // position in entry_index; the back maps it to natural order.
    typedef struct packed {
        kind_t       record_kind;
        logic [15:0] field_value;
        logic [7:0]  entry_index;
        logic [7:0]  component_id;
        logic [3:0]  horizontal_factor;
        logic [3:0]  vertical_factor;
        logic [3:0]  table_select;
        logic        last_in_segment;
    } rec_t;

    // Natural-order index for each zigzag position.
    localparam logic [5:0] ZIGZAG_NAT [QUANT_ENTRIES] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

endpackage

`default_nettype wire

>>> design/jpeg_header_marker_parser_top.sv
// JPEG header marker parser, top level: front end, record queue, output stage.
// Depends on jhp_pkg, jhp_front, jhp_queue and jhp_back.
//
// Usage:
//   The slave channel takes one stream byte per word in tdata; tuser set marks
//   the first byte of a new stream and restarts the parser on that byte. The
//   first two bytes must be FF D8, else a single "not JPEG" record is given and
//   the rest of the stream is dropped until the next start flag. After that,
//   SOF0, DQT and COM segments are turned into records on the master channel,
//   at most one record per input byte; tlast marks the last record of a segment.
//   Throughput is one byte per cycle while the queue is not full: the phase
//   machine updates once per byte and a four-word record queue decouples it
//   from the output. The record of an accepted byte is written into the queue
//   and then moved into the output register, which offers it on the master
//   channel. When the receiver stalls, records collect in the queue and the
//   output register; s_axis_tready drops only when the queue is full, and no
//   record is lost. Reset puts the parser in the expect-start-of-image phase
//   and empties the queue and output.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_header_marker_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tuser,   // [0] stream_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] field_value, [23:16] entry_index, [31:24] component_id,
    // [35:32] horizontal_factor, [39:36] vertical_factor,
    // [43:40] table_select, [47:44] zero
    output logic [47:0]      m_axis_tdata,
    output logic [3:0]       m_axis_tuser,   // [3:0] record_kind
    output logic             m_axis_tlast    // last_in_segment
);
    import jhp_pkg::*;

    rec_t  front_rec;
    rec_t  queue_rec;
    rec_t  out_rec;
    logic  front_push;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;
    logic  byte_accept;

    assign s_axis_tready = !queue_full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    jhp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_accept  (byte_accept),
        .byte_value   (s_axis_tdata),
        .stream_start (s_axis_tuser),
        .rec          (front_rec),
        .rec_push     (front_push)
    );

    jhp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_rec (front_rec),
        .pop      (queue_pop),
        .pop_rec  (queue_rec),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    jhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rec     (queue_rec),
        .q_empty   (queue_empty),
        .q_pop     (queue_pop),
        .out_rec   (out_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // Pack the output word, first field in the lowest bits.
    assign m_axis_tdata = {4'd0,
                           out_rec.table_select,
                           out_rec.vertical_factor,
                           out_rec.horizontal_factor,
                           out_rec.component_id,
                           out_rec.entry_index,
                           out_rec.field_value};
    assign m_axis_tuser = out_rec.record_kind;
    assign m_axis_tlast = out_rec.last_in_segment;

endmodule

`default_nettype wire

>>> design/jhp_front.sv
// Front end of the JPEG header marker parser: byte-level phase machine that
// turns accepted bytes into record words. Depends on jhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jhp_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_accept,
    input  wire logic [7:0]   byte_value,
    input  wire logic         stream_start,
    output jhp_pkg::rec_t     rec,
    output logic              rec_push
);
    import jhp_pkg::*;

    phase_t              phase_reg, phase_next, phase_cur;
    logic [7:0]          prev_reg, prev_next;
    logic [15:0]         remain_reg, remain_next;
    logic [1:0]          fcount_reg, fcount_next;
    logic [7:0]          comp_left_reg, comp_left_next;
    logic [7:0]          hold_reg, hold_next;
    logic                wide_reg, wide_next;
    logic [QPOS_W-1:0]   qpos_reg, qpos_next;
    logic [15:0]         com_len;
    logic [15:0]         remain_dec;
    logic [7:0]          comp_dec;
    logic                emit;

    // A start flag restarts the parse on this very byte.
    assign phase_cur  = stream_start ? PH_SOI0 : phase_reg;
    assign com_len    = {hold_reg, byte_value};
    assign remain_dec = remain_reg - 16'd1;
    assign comp_dec   = comp_left_reg - 8'd1;

    // Next-state logic.
    always_comb
    begin
        phase_next     = phase_cur;
        prev_next      = byte_value;
        remain_next    = remain_reg;
        fcount_next    = fcount_reg;
        comp_left_next = comp_left_reg;
        hold_next      = hold_reg;
        wide_next      = wide_reg;
        qpos_next      = qpos_reg;
        case (phase_cur)
            PH_SOI0:
            begin
                phase_next = PH_SOI1;
            end
            PH_SOI1:
            begin
                if (prev_reg == MARK_PREFIX && byte_value == MARK_SOI)
                    phase_next = PH_SCAN;
                else
                    phase_next = PH_DEAD;
            end
            PH_DEAD:
            begin
                phase_next = PH_DEAD;
            end
            PH_SOF_LEN, PH_DQT_LEN, PH_COM_LEN:
            begin
                if (fcount_reg == 2'd0)
                begin
                    hold_next   = byte_value;
                    fcount_next = 2'd1;
                end
                else
                begin
                    fcount_next = 2'd0;
                    if (phase_cur == PH_SOF_LEN)
                        phase_next = PH_SOF_PREC;
                    else if (phase_cur == PH_DQT_LEN)
                        phase_next = PH_DQT_HDR;
                    else
                    begin
                        remain_next = (com_len >= 16'd2) ? com_len - 16'd2 : 16'd0;
                        phase_next  = (com_len > 16'd2) ? PH_COM_BYTES : PH_SCAN;
                    end
                end
            end
            PH_SOF_PREC:
            begin
                phase_next = PH_SOF_H;
            end
            PH_SOF_H, PH_SOF_W:
            begin
                if (fcount_reg == 2'd0)
                begin
                    hold_next   = byte_value;
                    fcount_next = 2'd1;
                end
                else
                begin
                    fcount_next = 2'd0;
                    phase_next  = (phase_cur == PH_SOF_H) ? PH_SOF_W : PH_SOF_N;
                end
            end
            PH_SOF_N:
            begin
                comp_left_next = byte_value;
                remain_next    = {8'd0, byte_value};
                fcount_next    = 2'd0;
                phase_next     = (byte_value == 8'd0) ? PH_SCAN : PH_SOF_COMP;
            end
            PH_SOF_COMP:
            begin
                if (fcount_reg == 2'd0)
                begin
                    hold_next   = byte_value;
                    fcount_next = 2'd1;
                end
                else if (fcount_reg == 2'd1)
                    fcount_next = 2'd2;
                else
                begin
                    fcount_next    = 2'd0;
                    comp_left_next = comp_dec;
                    if (comp_dec == 8'd0)
                        phase_next = PH_SCAN;
                end
            end
            PH_DQT_HDR:
            begin
                wide_next   = (byte_value[7:4] != 4'd0);
                qpos_next   = '0;
                fcount_next = 2'd0;
                phase_next  = PH_DQT_ENT;
            end
            PH_DQT_ENT:
            begin
                if (wide_reg && fcount_reg == 2'd0)
                begin
                    hold_next   = byte_value;
                    fcount_next = 2'd1;
                end
                else
                begin
                    fcount_next = 2'd0;
                    qpos_next   = qpos_reg + 1'b1;
                    if (qpos_reg == QPOS_W'(QUANT_ENTRIES - 1))
                        phase_next = PH_SCAN;
                end
            end
            PH_COM_BYTES:
            begin
                remain_next = remain_dec;
                if (remain_dec == 16'd0)
                    phase_next = PH_SCAN;
            end
            PH_SCAN:
            begin
                if (prev_reg == MARK_PREFIX)
                begin
                    fcount_next = 2'd0;
                    if (byte_value == MARK_SOF0)
                        phase_next = PH_SOF_LEN;
                    else if (byte_value == MARK_DQT)
                        phase_next = PH_DQT_LEN;
                    else if (byte_value == MARK_COM)
                        phase_next = PH_COM_LEN;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase
    end

    // Record output logic.
    always_comb
    begin
        rec  = '0;
        emit = 1'b0;
        case (phase_cur)
            PH_SOI1:
            begin
                if (!(prev_reg == MARK_PREFIX && byte_value == MARK_SOI))
                begin
                    emit            = 1'b1;
                    rec.record_kind = KIND_NOT_JPEG;
                end
            end
            PH_SOF_PREC:
            begin
                emit            = 1'b1;
                rec.record_kind = KIND_PRECISION;
                rec.field_value = {8'd0, byte_value};
            end
            PH_SOF_H, PH_SOF_W:
            begin
                if (fcount_reg != 2'd0)
                begin
                    emit            = 1'b1;
                    rec.record_kind = (phase_cur == PH_SOF_H) ? KIND_HEIGHT : KIND_WIDTH;
                    rec.field_value = {hold_reg, byte_value};
                end
            end
            PH_SOF_N:
            begin
                emit                = 1'b1;
                rec.record_kind     = KIND_NCOMP;
                rec.field_value     = {8'd0, byte_value};
                rec.last_in_segment = (byte_value == 8'd0);
            end
            PH_SOF_COMP:
            begin
                if (fcount_reg == 2'd2)
                begin
                    emit                  = 1'b1;
                    rec.record_kind       = KIND_COMPONENT;
                    rec.entry_index       = remain_reg[7:0] - comp_left_reg;
                    rec.component_id      = hold_reg;
                    rec.horizontal_factor = prev_reg[7:4];
                    rec.vertical_factor   = prev_reg[3:0];
                    rec.table_select      = byte_value[3:0];
                    rec.last_in_segment   = (comp_dec == 8'd0);
                end
            end
            PH_DQT_HDR:
            begin
                emit            = 1'b1;
                rec.record_kind = KIND_QHEADER;
                rec.field_value = {12'd0, byte_value[7:4]} + 16'd1;
                rec.table_select = byte_value[3:0];
            end
            PH_DQT_ENT:
            begin
                if (!(wide_reg && fcount_reg == 2'd0))
                begin
                    emit                = 1'b1;
                    rec.record_kind     = KIND_QENTRY;
                    rec.field_value     = wide_reg ? {hold_reg, byte_value}
                                                   : {8'd0, byte_value};
                    rec.entry_index     = 8'(qpos_reg);
                    rec.last_in_segment = (qpos_reg == QPOS_W'(QUANT_ENTRIES - 1));
                end
            end
            PH_COM_BYTES:
            begin
                emit                = 1'b1;
                rec.record_kind     = KIND_COMMENT;
                rec.field_value     = {8'd0, byte_value};
                rec.last_in_segment = (remain_dec == 16'd0);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign rec_push = byte_accept && emit;

    // State registers advance once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SOI0;
            prev_reg      <= 8'd0;
            remain_reg    <= 16'd0;
            fcount_reg    <= 2'd0;
            comp_left_reg <= 8'd0;
            hold_reg      <= 8'd0;
            wide_reg      <= 1'b0;
            qpos_reg      <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            remain_reg    <= remain_next;
            fcount_reg    <= fcount_next;
            comp_left_reg <= comp_left_next;
            hold_reg      <= hold_next;
            wide_reg      <= wide_next;
            qpos_reg      <= qpos_next;
        end
    end

endmodule

`default_nettype wire

>>> design/jhp_queue.sv
// Short record queue between the parser front end and the output stage.
// Register-based, one write and one read port. Depends on jhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jhp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jhp_pkg::rec_t push_rec,
    input  wire logic          pop,
    output jhp_pkg::rec_t      pop_rec,
    output logic               full,
    output logic               empty
);
    import jhp_pkg::*;

    rec_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // A word is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue overflow");

    // A word is never taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue underflow");

    // The fill count rises on a push without a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");

    // Write and read pointers stay apart by the fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(count_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> design/jhp_back.sv
// Back end of the JPEG header marker parser: takes record words from the
// queue, maps quant entries to natural order and holds the output word.
// Depends on jhp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jhp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jhp_pkg::rec_t q_rec,
    input  wire logic          q_empty,
    output logic               q_pop,
    output jhp_pkg::rec_t      out_rec,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import jhp_pkg::*;

    rec_t  out_reg, out_next;
    logic  valid_reg;

    // Load a new word when the output is free or being taken.
    assign q_pop = !q_empty && (!valid_reg || out_ready);

    // Quant entries carry their zigzag position; turn it into natural order.
    always_comb
    begin
        out_next = q_rec;
        if (q_rec.record_kind == KIND_QENTRY)
            out_next.entry_index = {2'd0, ZIGZAG_NAT[q_rec.entry_index[QPOS_W-1:0]]};
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    assign out_rec   = out_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire
